FILE: rtl/hrhp_pkg.sv
package hrhp_pkg;

    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_URI     = 4'd1;
    localparam logic [3:0] PH_QUERY   = 4'd2;
    localparam logic [3:0] PH_VERSION = 4'd3;
    localparam logic [3:0] PH_NAME    = 4'd4;
    localparam logic [3:0] PH_SPACE   = 4'd5;
    localparam logic [3:0] PH_VALUE   = 4'd6;
    localparam logic [3:0] PH_LF      = 4'd7;
    localparam logic [3:0] PH_LINE    = 4'd8;
    localparam logic [3:0] PH_LAST_LF = 4'd9;
    localparam logic [3:0] PH_BODY    = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;
    localparam logic [3:0] PH_ERROR   = 4'd12;

    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_BODY  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [3:0] METHOD_LIMIT_RESET = 4'd8;

    localparam int OUT_BYTES = 25;

    typedef struct packed {
        logic [15:0] body_offset;
        logic [15:0] header_block_length;
        logic [15:0] header_block_offset;
        logic [15:0] query_length;
        logic [15:0] query_offset;
        logic [15:0] uri_length;
        logic [15:0] uri_offset;
        logic [31:0] body_length;
        logic        keep_alive_flag;
        logic [1:0]  protocol_version;
        logic [3:0]  method_code;
        logic [1:0]  parse_status;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] k);
        logic [55:0] s;
        case (m)
            3'd0: s = {"GET", 32'h0};
            3'd1: s = {"POST", 24'h0};
            3'd2: s = {"HEAD", 24'h0};
            3'd3: s = {"PUT", 32'h0};
            3'd4: s = {"DELETE", 8'h0};
            3'd5: s = {"TRACE", 16'h0};
            3'd6: s = "CONNECT";
            default: s = "OPTIONS";
        endcase
        meth_char = s[8'd55 - {k, 3'd0} -: 8];
    endfunction

    function automatic logic [2:0] meth_len(input logic [2:0] m);
        case (m)
            3'd0, 3'd3: meth_len = 3'd3;
            3'd1, 3'd2: meth_len = 3'd4;
            3'd4: meth_len = 3'd6;
            3'd5: meth_len = 3'd5;
            default: meth_len = 3'd7;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] k);
        logic [79:0] s;
        s = "HTTP/1.0\r\n";
        ver_char = (k > 4'd9) ? 8'h00 : s[8'd79 - {k, 3'd0} -: 8];
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] k);
        logic [79:0] s;
        s = "connection";
        conn_char = (k > 4'd9) ? 8'h00 : s[8'd79 - {k, 3'd0} -: 8];
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] k);
        logic [111:0] s;
        s = "content-length";
        clen_char = (k > 4'd13) ? 8'h00 : s[8'd111 - {k, 3'd0} -: 8];
    endfunction

    function automatic logic [7:0] ka_char(input logic [3:0] k);
        logic [79:0] s;
        s = "keep-alive";
        ka_char = (k > 4'd9) ? 8'h00 : s[8'd79 - {k, 3'd0} -: 8];
    endfunction

endpackage

FILE: rtl/hrhp_core.sv
module hrhp_core #(
    parameter int MAX_REQUEST_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    input  logic [3:0]           i_limit,
    output hrhp_pkg::t_result    o_result
);
    localparam int PW = $clog2(MAX_REQUEST_BYTES + 1);

    logic [3:0]  r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]  r_mcand, n_mcand;
    logic [3:0]  r_vidx, n_vidx;
    logic [1:0]  r_vcand, n_vcand;
    logic [1:0]  r_nflags, n_nflags;
    logic [3:0]  r_nidx, n_nidx;
    logic [4:0]  r_vstate, n_vstate;
    logic [31:0] r_brem, n_brem;
    logic [3:0]  r_meth, n_meth;
    logic [1:0]  r_ver, n_ver;
    logic        r_ka, n_ka;
    logic [31:0] r_blen, n_blen;
    logic [15:0] r_uoff, n_uoff, r_ulen, n_ulen, r_qoff, n_qoff, r_qlen, n_qlen;
    logic [15:0] r_hoff, n_hoff, r_hlen, n_hlen, r_boff, n_boff;

    logic [3:0]  s_phase;
    logic [PW-1:0] s_pos;
    logic [7:0]  s_mcand;
    logic [3:0]  s_vidx, s_nidx;
    logic [1:0]  s_vcand, s_nflags;
    logic [4:0]  s_vstate;
    logic [31:0] s_brem, s_blen;
    logic [3:0]  s_meth;
    logic [1:0]  s_ver;
    logic        s_ka;
    logic [15:0] s_uoff, s_ulen, s_qoff, s_qlen, s_hoff, s_hlen, s_boff;
    logic [15:0] p16, p1;
    logic [7:0]  c, f;
    logic [1:0]  vc;
    logic [3:0]  cnt;
    logic        stp;
    logic [35:0] prod;
    logic [35:0] acc;
    logic [1:0]  cls;
    logic [1:0]  st;

    always_comb begin
        s_phase = i_first ? hrhp_pkg::PH_METHOD : r_phase;
        s_pos = i_first ? '0 : r_pos;
        s_mcand = i_first ? 8'hFF : r_mcand;
        s_vidx = i_first ? 4'd0 : r_vidx;
        s_vcand = i_first ? 2'b11 : r_vcand;
        s_nflags = i_first ? 2'b11 : r_nflags;
        s_nidx = i_first ? 4'd0 : r_nidx;
        s_vstate = i_first ? 5'd0 : r_vstate;
        s_brem = i_first ? 32'd0 : r_brem;
        s_meth = i_first ? 4'd0 : r_meth;
        s_ver = i_first ? 2'd0 : r_ver;
        s_ka = i_first ? 1'b0 : r_ka;
        s_blen = i_first ? 32'd0 : r_blen;
        s_uoff = i_first ? 16'd0 : r_uoff;
        s_ulen = i_first ? 16'd0 : r_ulen;
        s_qoff = i_first ? 16'd0 : r_qoff;
        s_qlen = i_first ? 16'd0 : r_qlen;
        s_hoff = i_first ? 16'd0 : r_hoff;
        s_hlen = i_first ? 16'd0 : r_hlen;
        s_boff = i_first ? 16'd0 : r_boff;

        n_phase = s_phase; n_pos = s_pos; n_mcand = s_mcand; n_vidx = s_vidx;
        n_vcand = s_vcand; n_nflags = s_nflags; n_nidx = s_nidx; n_vstate = s_vstate;
        n_brem = s_brem; n_meth = s_meth; n_ver = s_ver; n_ka = s_ka; n_blen = s_blen;
        n_uoff = s_uoff; n_ulen = s_ulen; n_qoff = s_qoff; n_qlen = s_qlen;
        n_hoff = s_hoff; n_hlen = s_hlen; n_boff = s_boff;

        c = i_byte;
        f = hrhp_pkg::fold(c);
        p16 = 16'(s_pos);
        p1 = p16 + 16'd1;
        vc = s_vcand;
        cnt = s_vstate[3:0];
        stp = s_vstate[4];
        prod = 36'(s_brem) * 36'd10;
        acc = prod + 36'(c - 8'h30);
        cls = 2'b00;

        if (s_phase != hrhp_pkg::PH_DONE && s_phase != hrhp_pkg::PH_ERROR) begin
            if (32'(s_pos) >= 32'(MAX_REQUEST_BYTES)) begin
                n_phase = hrhp_pkg::PH_ERROR;
            end else begin
                n_pos = s_pos + PW'(1);
                case (s_phase)
                    hrhp_pkg::PH_METHOD: begin
                        if (c == 8'h20) begin
                            for (int i = 7; i >= 0; i--) begin
                                if (s_mcand[i] &&
                                    32'(hrhp_pkg::meth_len(3'(i))) == 32'(s_pos))
                                    n_meth = 4'(i + 1);
                            end
                            if (n_meth == 4'd0) begin
                                n_phase = hrhp_pkg::PH_ERROR;
                                n_pos = s_pos;
                            end else begin
                                n_uoff = p1;
                                n_phase = hrhp_pkg::PH_URI;
                            end
                        end else if (32'(s_pos) >= 32'(i_limit)) begin
                            n_phase = hrhp_pkg::PH_ERROR;
                            n_pos = s_pos;
                        end else begin
                            for (int i = 0; i < 8; i++) begin
                                if (32'(s_pos) >= 32'(hrhp_pkg::meth_len(3'(i))) ||
                                    hrhp_pkg::meth_char(3'(i), s_pos[2:0]) != c)
                                    n_mcand[i] = 1'b0;
                            end
                        end
                    end
                    hrhp_pkg::PH_URI: begin
                        if (c == 8'h20 || c == 8'h3F) begin
                            n_ulen = p16 - s_uoff;
                            if (c == 8'h20) n_phase = hrhp_pkg::PH_VERSION;
                            else begin
                                n_qoff = p1;
                                n_phase = hrhp_pkg::PH_QUERY;
                            end
                        end
                    end
                    hrhp_pkg::PH_QUERY: begin
                        if (c == 8'h20) begin
                            n_qlen = p16 - s_qoff;
                            n_phase = hrhp_pkg::PH_VERSION;
                        end
                    end
                    hrhp_pkg::PH_VERSION: begin
                        if (s_vidx > 4'd9) begin
                            n_phase = hrhp_pkg::PH_ERROR;
                            n_pos = s_pos;
                        end else begin
                            if (hrhp_pkg::ver_char(s_vidx) != c) vc[0] = 1'b0;
                            if ((s_vidx == 4'd7 ? 8'h31 : hrhp_pkg::ver_char(s_vidx)) != c)
                                vc[1] = 1'b0;
                            n_vcand = vc;
                            if (vc == 2'b00) begin
                                n_phase = hrhp_pkg::PH_ERROR;
                                n_pos = s_pos;
                            end else if (s_vidx == 4'd9) begin
                                n_ver = vc[0] ? 2'd1 : 2'd2;
                                n_hoff = p1;
                                n_nflags = 2'b11;
                                n_nidx = 4'd0;
                                n_phase = hrhp_pkg::PH_NAME;
                            end else begin
                                n_vidx = s_vidx + 4'd1;
                            end
                        end
                    end
                    hrhp_pkg::PH_NAME, hrhp_pkg::PH_LINE: begin
                        if (s_phase == hrhp_pkg::PH_LINE && c == 8'h0D) begin
                            n_phase = hrhp_pkg::PH_LAST_LF;
                        end else if (s_phase == hrhp_pkg::PH_NAME && c == 8'h3A) begin
                            cls[0] = s_nflags[0] && s_nidx >= 4'd10;
                            cls[1] = s_nflags[1] && s_nidx >= 4'd14;
                            n_nflags = cls;
                            n_vstate = 5'd0;
                            n_brem = 32'd0;
                            n_phase = hrhp_pkg::PH_SPACE;
                        end else begin
                            if (s_phase == hrhp_pkg::PH_LINE) begin
                                n_nflags = 2'b11;
                                n_nidx = 4'd0;
                            end
                            if (n_nidx < 4'd10 && f != hrhp_pkg::conn_char(n_nidx))
                                n_nflags[0] = 1'b0;
                            if (n_nidx < 4'd14 && f != hrhp_pkg::clen_char(n_nidx))
                                n_nflags[1] = 1'b0;
                            if (n_nidx < 4'd15) n_nidx = n_nidx + 4'd1;
                            n_phase = hrhp_pkg::PH_NAME;
                        end
                    end
                    hrhp_pkg::PH_SPACE, hrhp_pkg::PH_VALUE: begin
                        if (!(s_phase == hrhp_pkg::PH_SPACE && c == 8'h20)) begin
                            n_phase = hrhp_pkg::PH_VALUE;
                            if (c == 8'h0D) begin
                                if (s_nflags[0])
                                    n_ka = !stp && cnt == 4'd10;
                                if (s_nflags[1]) n_blen = s_brem;
                                n_phase = hrhp_pkg::PH_LF;
                            end else begin
                                if (s_nflags[0] && !stp && cnt < 4'd10) begin
                                    if (f == hrhp_pkg::ka_char(cnt)) cnt = cnt + 4'd1;
                                    else stp = 1'b1;
                                end
                                if (s_nflags[1] && !stp) begin
                                    if (c >= 8'h30 && c <= 8'h39)
                                        n_brem = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                      : acc[31:0];
                                    else stp = 1'b1;
                                end
                                n_vstate = {stp, cnt};
                            end
                        end
                    end
                    hrhp_pkg::PH_LF: begin
                        if (c != 8'h0A) begin
                            n_phase = hrhp_pkg::PH_ERROR;
                            n_pos = s_pos;
                        end else n_phase = hrhp_pkg::PH_LINE;
                    end
                    hrhp_pkg::PH_LAST_LF: begin
                        if (c != 8'h0A) begin
                            n_phase = hrhp_pkg::PH_ERROR;
                            n_pos = s_pos;
                        end else begin
                            n_hlen = p16 - s_hoff - 16'd3;
                            n_boff = p1;
                            n_brem = s_blen;
                            n_phase = (s_blen != 32'd0) ? hrhp_pkg::PH_BODY
                                                        : hrhp_pkg::PH_DONE;
                        end
                    end
                    hrhp_pkg::PH_BODY: begin
                        n_brem = s_brem - 32'd1;
                        if (s_brem == 32'd1) n_phase = hrhp_pkg::PH_DONE;
                    end
                    default: begin
                        n_phase = hrhp_pkg::PH_ERROR;
                        n_pos = s_pos;
                    end
                endcase
            end
        end

        if (n_phase == hrhp_pkg::PH_ERROR) st = hrhp_pkg::ST_ERROR;
        else if (n_phase == hrhp_pkg::PH_DONE) st = hrhp_pkg::ST_DONE;
        else if (n_phase == hrhp_pkg::PH_BODY) st = hrhp_pkg::ST_BODY;
        else st = hrhp_pkg::ST_BUSY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrhp_pkg::PH_METHOD; r_pos <= '0; r_mcand <= 8'hFF;
            r_vidx <= 4'd0; r_vcand <= 2'b11; r_nflags <= 2'b11; r_nidx <= 4'd0;
            r_vstate <= 5'd0; r_brem <= 32'd0; r_meth <= 4'd0; r_ver <= 2'd0;
            r_ka <= 1'b0; r_blen <= 32'd0; r_uoff <= 16'd0; r_ulen <= 16'd0;
            r_qoff <= 16'd0; r_qlen <= 16'd0; r_hoff <= 16'd0; r_hlen <= 16'd0;
            r_boff <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase; r_pos <= n_pos; r_mcand <= n_mcand;
            r_vidx <= n_vidx; r_vcand <= n_vcand; r_nflags <= n_nflags; r_nidx <= n_nidx;
            r_vstate <= n_vstate; r_brem <= n_brem; r_meth <= n_meth; r_ver <= n_ver;
            r_ka <= n_ka; r_blen <= n_blen; r_uoff <= n_uoff; r_ulen <= n_ulen;
            r_qoff <= n_qoff; r_qlen <= n_qlen; r_hoff <= n_hoff; r_hlen <= n_hlen;
            r_boff <= n_boff;
        end
    end

    always_comb begin
        o_result.parse_status = st;
        o_result.method_code = n_meth;
        o_result.protocol_version = n_ver;
        o_result.keep_alive_flag = n_ka;
        o_result.body_length = n_blen;
        o_result.uri_offset = n_uoff;
        o_result.uri_length = n_ulen;
        o_result.query_offset = n_qoff;
        o_result.query_length = n_qlen;
        o_result.header_block_offset = n_hoff;
        o_result.header_block_length = n_hlen;
        o_result.body_offset = n_boff;
    end
endmodule

FILE: rtl/http_request_header_parser_unit.sv
// HTTP request header parser.
// s_axis: one request byte per transfer; tdata = data_byte, tuser = first_byte
// (a set first_byte restarts the parse at offset 0).
// m_axis: one result per input byte; tdata fields from bit 0 up: parse_status,
// method_code, protocol_version, keep_alive_flag, body_length, uri_offset,
// uri_length, query_offset, query_length, header_block_offset,
// header_block_length, body_offset, zero padded to 200 bits.
// cfg: i_cfg_valid/o_cfg_ready write method_length_limit (reset 8); write
// only while idle.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one byte per cycle unless the receiver stalls; the parser state
// updates through matcher logic and the result sits in one output register.
// When the receiver stalls the result is held and the input is taken only
// while the output register is empty or being drained.
// Reset clears the parser to the method phase and empties the output.
module http_request_header_parser_unit #(
    parameter int MAX_REQUEST_BYTES = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // first_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,   // see head comment
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_data
);
    logic              r_valid;
    logic [3:0]        r_limit;
    hrhp_pkg::t_result r_res;
    hrhp_pkg::t_result w_res;
    logic              w_step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_step = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    hrhp_core #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step),
        .i_byte(s_axis_tdata), .i_first(s_axis_tuser), .i_limit(r_limit),
        .o_result(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_limit <= hrhp_pkg::METHOD_LIMIT_RESET;
        end else begin
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (w_step) r_valid <= 1'b1;
            else if (m_axis_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) r_res <= w_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = (hrhp_pkg::OUT_BYTES * 8)'(r_res);
endmodule
